FILE: design/crd_pkg.sv
// Shared types, constants and helper functions of the collision residual detector.
// No dependencies; every other file in the design takes this package in.
package crd_pkg;

  // Number of joint axes and the width of the time accumulators.
  localparam int AXES      = 6;
  localparam int TIME_BITS = 24;

  // Fixed field widths.
  localparam int RES_W    = 20;
  localparam int MAG_W    = 20;
  localparam int TH_W     = 16;
  localparam int AXIS_W   = 3;
  localparam int DT_W     = 16;
  localparam int REL_W    = 17;
  localparam int CFGT_W   = 24;
  localparam int THR_W    = 48;
  localparam int IDX_W    = 3;
  localparam int DATA_W   = 48;
  localparam int RATIO_SH = 16;
  localparam int WIDE_W   = 32;
  localparam int TH_AXES  = 3;

  // Compare tree geometry.
  localparam int LEVELS = (AXES > 1) ? $clog2(AXES) : 0;
  localparam int LEAVES = 1 << LEVELS;
  localparam int NODES  = (LEAVES > 1) ? LEAVES - 1 : 1;
  // Lane stage, one stage per tree level, release stage.
  localparam int NSTAGE = LEVELS + 2;

  localparam logic [REL_W-1:0]  REL_MIN   = REL_W'(3277);
  localparam logic [REL_W-1:0]  REL_MAX   = REL_W'(65536);
  localparam logic [REL_W-1:0]  REL_RESET = REL_W'(62259);
  localparam logic [WIDE_W-1:0] TIME_MAX_W = WIDE_W'((64'd1 << TIME_BITS) - 64'd1);

  typedef logic [TIME_BITS-1:0] crd_time_t;

  typedef enum logic [IDX_W-1:0] {
    REG_DETECT_ENABLE = 3'd0,
    REG_THR_LOW       = 3'd1,
    REG_THR_HIGH      = 3'd2,
    REG_RELEASE_RATIO = 3'd3,
    REG_CONFIRM       = 3'd4,
    REG_DEBOUNCE      = 3'd5
  } crd_reg_e;

  // One ratio candidate: magnitude over threshold, with the axis it came from.
  typedef struct packed {
    logic [MAG_W-1:0]  mag;
    logic [TH_W-1:0]   th;
    logic [AXIS_W-1:0] axis;
  } crd_node_t;

  // What the merging stage reports for one sample.
  typedef struct packed {
    logic [AXIS_W-1:0] axis;
    logic              keep;
    logic              over;
  } crd_pick_t;

  // True when the ratio of a is strictly greater than the ratio of b.
  function automatic logic ratio_gt(input crd_node_t a, input crd_node_t b);
    logic [MAG_W+TH_W-1:0] lhs;
    logic [MAG_W+TH_W-1:0] rhs;
    lhs = a.mag * b.th;
    rhs = b.mag * a.th;
    return lhs > rhs;
  endfunction

  // Clamps a wide time value to the largest value the accumulators hold.
  function automatic crd_time_t sat_time(input logic [WIDE_W-1:0] v);
    crd_time_t r;
    if (v > TIME_MAX_W) begin
      r = '1;
    end else begin
      r = v[TIME_BITS-1:0];
    end
    return r;
  endfunction

endpackage

FILE: design/crd_lane.sv
// One axis lane: absolute residual and threshold, registered as a ratio candidate.
// Depends on crd_pkg.
module crd_lane
  import crd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [RES_W-1:0]  residual_i,
  input  logic        [TH_W-1:0]   threshold_i,
  input  logic        [AXIS_W-1:0] axis_i,
  output crd_node_t                node_o
);

  logic [MAG_W-1:0] mag;
  crd_node_t        node_d;
  crd_node_t        node_q;

  // The most negative residual maps onto its own bit pattern, which is the right magnitude.
  assign mag = residual_i[RES_W-1] ? MAG_W'(~residual_i + 1'b1) : MAG_W'(residual_i);

  // A zero ratio is written as 0/1 so that it never wins against the empty start value.
  always_comb begin
    node_d.axis = axis_i;
    if (threshold_i == '0 || mag == '0) begin
      node_d.mag = '0;
      node_d.th  = TH_W'(1);
    end else begin
      node_d.mag = mag;
      node_d.th  = threshold_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      node_q <= node_d;
    end
  end

  assign node_o = node_q;

endmodule

FILE: design/crd_merge.sv
// Registered compare tree over the lane candidates, followed by the release check.
// Depends on crd_pkg.
module crd_merge
  import crd_pkg::*;
(
  input  logic                clk_i,
  input  logic [LEVELS:0]     en_i,
  input  crd_node_t           leaf_i [LEAVES],
  input  logic [REL_W-1:0]    release_ratio_i,
  output crd_pick_t           pick_o
);

  crd_node_t node_q [1:NODES];
  crd_node_t root;

  // Heap order: node n has children 2n and 2n+1; children past the last node are leaves.
  // The left child keeps ties, so the lowest axis wins among equal ratios.
  for (genvar n = 1; n < LEAVES; n++) begin : g_node
    localparam int D = $clog2(n + 1) - 1;
    crd_node_t lft;
    crd_node_t rgt;
    if (2 * n >= LEAVES) begin : g_leaf
      assign lft = leaf_i[2 * n - LEAVES];
      assign rgt = leaf_i[2 * n + 1 - LEAVES];
    end else begin : g_inner
      assign lft = node_q[2 * n];
      assign rgt = node_q[2 * n + 1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i[LEVELS - D - 1]) begin
        node_q[n] <= ratio_gt(rgt, lft) ? rgt : lft;
      end
    end
  end

  if (LEVELS == 0) begin : g_single
    assign root = leaf_i[0];
  end else begin : g_tree
    assign root = node_q[1];
  end

  logic [REL_W-1:0]           rel;
  logic [REL_W+TH_W-1:0]      rel_prod;
  logic [MAG_W+RATIO_SH-1:0]  lhs;
  crd_pick_t                  pick_d;
  crd_pick_t                  pick_q;

  always_comb begin
    if (release_ratio_i < REL_MIN) begin
      rel = REL_MIN;
    end else if (release_ratio_i > REL_MAX) begin
      rel = REL_MAX;
    end else begin
      rel = release_ratio_i;
    end
    rel_prod    = rel * root.th;
    lhs         = {root.mag, {RATIO_SH{1'b0}}};
    pick_d.axis = root.axis;
    pick_d.keep = !(lhs < (MAG_W+RATIO_SH)'(rel_prod));
    pick_d.over = root.mag > MAG_W'(root.th);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[LEVELS]) begin
      pick_q <= pick_d;
    end
  end

  assign pick_o = pick_q;

endmodule

FILE: design/collision_residual_detector.sv
// One sample per cycle while the result channel is not stalled; the lanes, each level of
// the compare tree and the release multiplier are all registered stages, and the state
// update sits in the last stage. Reset clears configuration (release ratio to 62259),
// candidate and lockout state and all valid flags; no clearing pass is needed, so the
// block is ready as soon as reset is released.
// Depends on crd_pkg, crd_lane and crd_merge.
module collision_residual_detector
  import crd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration write channel.
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [IDX_W-1:0]        cfg_index_i,
  input  logic [DATA_W-1:0]       cfg_data_i,
  // Sample input channel.
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [RES_W-1:0] residual_axis0_i,
  input  logic signed [RES_W-1:0] residual_axis1_i,
  input  logic signed [RES_W-1:0] residual_axis2_i,
  input  logic signed [RES_W-1:0] residual_axis3_i,
  input  logic signed [RES_W-1:0] residual_axis4_i,
  input  logic signed [RES_W-1:0] residual_axis5_i,
  input  logic [DT_W-1:0]         elapsed_us_i,
  // Result output channel.
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    collision_o,
  output logic [AXIS_W-1:0]       contact_axis_o,
  output logic                    suspect_active_o,
  output logic [AXIS_W-1:0]       suspect_axis_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; unknown indices are dropped.
  // ---------------------------------------------------------------------------
  logic              enable_q;
  logic [THR_W-1:0]  thr_low_q;
  logic [THR_W-1:0]  thr_high_q;
  logic [REL_W-1:0]  release_q;
  logic [CFGT_W-1:0] confirm_q;
  logic [CFGT_W-1:0] debounce_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      thr_low_q  <= '0;
      thr_high_q <= '0;
      release_q  <= REL_RESET;
      confirm_q  <= '0;
      debounce_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (crd_reg_e'(cfg_index_i))
        REG_DETECT_ENABLE: enable_q   <= cfg_data_i[0];
        REG_THR_LOW:       thr_low_q  <= cfg_data_i[THR_W-1:0];
        REG_THR_HIGH:      thr_high_q <= cfg_data_i[THR_W-1:0];
        REG_RELEASE_RATIO: release_q  <= cfg_data_i[REL_W-1:0];
        REG_CONFIRM:       confirm_q  <= cfg_data_i[CFGT_W-1:0];
        REG_DEBOUNCE:      debounce_q <= cfg_data_i[CFGT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. Each stage moves on when it is empty or when the stage
  // after it moves, so bubbles close up and a stalled result does not stop
  // samples entering while there is room behind it.
  // ---------------------------------------------------------------------------
  logic [NSTAGE-1:0] v_q;
  logic [NSTAGE-1:0] en;
  logic              out_en;
  logic              out_valid_q;
  logic [DT_W-1:0]   dt_q [NSTAGE];

  always_comb begin
    out_en           = !out_valid_q || out_ready_i;
    en[NSTAGE-1]     = !v_q[NSTAGE-1] || out_en;
    for (int s = NSTAGE - 2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int s = 1; s < NSTAGE; s++) begin
        if (en[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  // The elapsed time rides alongside the sample until the state update uses it.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dt_q[0] <= elapsed_us_i;
    end
    for (int s = 1; s < NSTAGE; s++) begin
      if (en[s]) begin
        dt_q[s] <= dt_q[s-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Lanes: one per axis; padding lanes see zero residual and zero threshold and so
  // carry a zero ratio that never wins.
  // ---------------------------------------------------------------------------
  logic signed [RES_W-1:0] res [6];
  crd_node_t               leaf [LEAVES];

  assign res[0] = residual_axis0_i;
  assign res[1] = residual_axis1_i;
  assign res[2] = residual_axis2_i;
  assign res[3] = residual_axis3_i;
  assign res[4] = residual_axis4_i;
  assign res[5] = residual_axis5_i;

  for (genvar a = 0; a < LEAVES; a++) begin : g_lane
    logic signed [RES_W-1:0] lane_res;
    logic [TH_W-1:0]         lane_th;
    if (a < AXES && a < TH_AXES) begin : g_low
      assign lane_res = res[a];
      assign lane_th  = thr_low_q[TH_W*a +: TH_W];
    end else if (a < AXES && a < 2 * TH_AXES) begin : g_high
      assign lane_res = res[a];
      assign lane_th  = thr_high_q[TH_W*(a-TH_AXES) +: TH_W];
    end else begin : g_pad
      assign lane_res = '0;
      assign lane_th  = '0;
    end
    crd_lane u_lane (
      .clk_i       (clk_i),
      .en_i        (en[0]),
      .residual_i  (lane_res),
      .threshold_i (lane_th),
      .axis_i      (AXIS_W'(a)),
      .node_o      (leaf[a])
    );
  end

  // ---------------------------------------------------------------------------
  // Merging stage: strongest ratio, release check and over-threshold flag.
  // ---------------------------------------------------------------------------
  crd_pick_t pick;

  crd_merge u_merge (
    .clk_i           (clk_i),
    .en_i            (en[NSTAGE-1:1]),
    .leaf_i          (leaf),
    .release_ratio_i (release_q),
    .pick_o          (pick)
  );

  // ---------------------------------------------------------------------------
  // Candidate tracking and confirmation. State changes only when the sample in the
  // last stage is handed to the output register, so samples update it in order.
  // ---------------------------------------------------------------------------
  logic              active_q, active_d;
  logic [AXIS_W-1:0] axis_q, axis_d;
  crd_time_t         ctime_q, ctime_d;
  crd_time_t         lock_q, lock_d;
  logic              hit;
  logic [AXIS_W-1:0] hit_axis;
  logic              commit;
  crd_time_t         dt_ext;
  crd_time_t         lock_dec;
  logic [TIME_BITS:0] ctime_sum;

  assign commit = v_q[NSTAGE-1] && out_en;
  assign dt_ext = TIME_BITS'(dt_q[NSTAGE-1]);

  always_comb begin
    lock_dec  = (lock_q > dt_ext) ? (lock_q - dt_ext) : '0;
    ctime_sum = {1'b0, ctime_q} + {1'b0, dt_ext};
    active_d  = active_q;
    axis_d    = axis_q;
    ctime_d   = ctime_q;
    lock_d    = lock_dec;
    hit       = 1'b0;
    hit_axis  = '0;
    if (!enable_q || !pick.keep) begin
      // Detection off, or the strongest ratio fell below the release ratio.
      active_d = 1'b0;
      ctime_d  = '0;
    end else begin
      if (!active_q || axis_q != pick.axis) begin
        // A new axis starts its own time over threshold.
        active_d = 1'b1;
        axis_d   = pick.axis;
        ctime_d  = dt_ext;
      end else begin
        ctime_d = ctime_sum[TIME_BITS] ? '1 : ctime_sum[TIME_BITS-1:0];
      end
      if (pick.over && lock_dec == '0 &&
          WIDE_W'(ctime_d) >= WIDE_W'(confirm_q)) begin
        lock_d   = sat_time(WIDE_W'(debounce_q));
        active_d = 1'b0;
        ctime_d  = '0;
        hit      = 1'b1;
        hit_axis = pick.axis;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      axis_q   <= '0;
      ctime_q  <= '0;
      lock_q   <= '0;
    end else if (commit) begin
      active_q <= active_d;
      axis_q   <= axis_d;
      ctime_q  <= ctime_d;
      lock_q   <= lock_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  logic              coll_q;
  logic [AXIS_W-1:0] coll_axis_q;
  logic              susp_q;
  logic [AXIS_W-1:0] susp_axis_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= v_q[NSTAGE-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      coll_q      <= hit;
      coll_axis_q <= hit_axis;
      susp_q      <= active_d;
      susp_axis_q <= active_d ? axis_d : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign collision_o      = coll_q;
  assign contact_axis_o   = coll_axis_q;
  assign suspect_active_o = susp_q;
  assign suspect_axis_o   = susp_axis_q;

endmodule

FILE: bench/tb_collision_residual_detector.sv
// Self-checking bench for collision_residual_detector: directed and random torque samples,
// with every result beat compared against a predictor of the detector kept in this file.
// Depends on crd_pkg and the detector RTL only.
module tb_collision_residual_detector;
  import crd_pkg::*;

  // Pipeline depth from an input beat to its result beat, used for the settling waits.
  localparam int LAT         = LEVELS + 3;
  // Longest run of cycles without any beat before the run is declared hung. The long
  // receiver hold-off below is much shorter than this, so it leaves ample margin.
  localparam int STALL_LIMIT = 2000;
  localparam int GAP_MAX     = 12;
  localparam int HOLD_CYCLES = 300;
  localparam logic [63:0] TIME_TOP = (64'd1 << TIME_BITS) - 64'd1;

  // One torque sample as it is offered on the input channel.
  typedef struct packed {
    logic [AXES-1:0][RES_W-1:0] res;
    logic [DT_W-1:0]            dt;
  } sample_t;

  // The four fields of one result beat.
  typedef struct packed {
    logic              collision;
    logic [AXIS_W-1:0] contact_axis;
    logic              suspect_active;
    logic [AXIS_W-1:0] suspect_axis;
  } verdict_t;

  // How strongly a residual is drawn relative to the threshold of its axis.
  typedef enum int {
    MAG_QUIET,
    MAG_NEAR,
    MAG_STRONG,
    MAG_ANY
  } mag_kind_e;

  // Every input of the block starts from a known value.
  logic                    clk_i            = 1'b0;
  logic                    rst_ni           = 1'b0;
  logic                    cfg_valid_i      = 1'b0;
  logic                    cfg_ready_o;
  logic [IDX_W-1:0]        cfg_index_i      = '0;
  logic [DATA_W-1:0]       cfg_data_i       = '0;
  logic                    in_valid_i       = 1'b0;
  logic                    in_ready_o;
  logic signed [RES_W-1:0] residual_axis0_i = '0;
  logic signed [RES_W-1:0] residual_axis1_i = '0;
  logic signed [RES_W-1:0] residual_axis2_i = '0;
  logic signed [RES_W-1:0] residual_axis3_i = '0;
  logic signed [RES_W-1:0] residual_axis4_i = '0;
  logic signed [RES_W-1:0] residual_axis5_i = '0;
  logic [DT_W-1:0]         elapsed_us_i     = '0;
  logic                    out_valid_o;
  logic                    out_ready_i      = 1'b0;
  logic                    collision_o;
  logic [AXIS_W-1:0]       contact_axis_o;
  logic                    suspect_active_o;
  logic [AXIS_W-1:0]       suspect_axis_o;

  // Predictor copy of the configuration registers, at their reset values.
  logic              det_en       = 1'b0;
  logic [THR_W-1:0]  thr_lo       = '0;
  logic [THR_W-1:0]  thr_hi       = '0;
  logic [REL_W-1:0]  rel_cfg      = REL_RESET;
  logic [CFGT_W-1:0] confirm_cfg  = '0;
  logic [CFGT_W-1:0] debounce_cfg = '0;

  // Predictor copy of the candidate tracker and the lockout timer.
  logic              cand_on   = 1'b0;
  logic [AXIS_W-1:0] cand_axis = '0;
  crd_time_t         cand_time = '0;
  crd_time_t         lock_left = '0;

  sample_t  sample_q[$];    // samples waiting to be offered
  verdict_t verdict_q[$];   // predicted result beats, oldest first
  sample_t  cur_sample;

  int errors       = 0;
  int in_gap       = 0;
  int out_gap      = 0;
  int in_gap_max   = 0;
  int out_gap_max  = 0;
  int rx_hold_left = 0;
  int stall_cycles = 0;
  bit in_taken     = 1'b0;

  collision_residual_detector dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .residual_axis0_i (residual_axis0_i),
    .residual_axis1_i (residual_axis1_i),
    .residual_axis2_i (residual_axis2_i),
    .residual_axis3_i (residual_axis3_i),
    .residual_axis4_i (residual_axis4_i),
    .residual_axis5_i (residual_axis5_i),
    .elapsed_us_i     (elapsed_us_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .collision_o      (collision_o),
    .contact_axis_o   (contact_axis_o),
    .suspect_active_o (suspect_active_o),
    .suspect_axis_o   (suspect_axis_o)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  // Threshold of one axis as packed in the two threshold registers; axes past the sixth
  // have none.
  function automatic logic [TH_W-1:0] thr_of(input int a);
    if (a < TH_AXES) begin
      return thr_lo[TH_W*a +: TH_W];
    end
    if (a < 2 * TH_AXES) begin
      return thr_hi[TH_W*(a-TH_AXES) +: TH_W];
    end
    return '0;
  endfunction

  // Advances the tracker by one accepted sample and returns the beat it must produce.
  // Ratios are compared by cross products, so all arithmetic stays exact in 64 bits.
  function automatic verdict_t judge_sample(input sample_t s);
    verdict_t          v;
    logic [63:0]       best_r;
    logic [63:0]       best_t;
    logic [63:0]       mag;
    logic [63:0]       th;
    logic [63:0]       rel;
    logic [63:0]       acc;
    logic [RES_W-1:0]  raw;
    logic [AXIS_W-1:0] best_axis;
    int                a;
    v         = '0;
    best_r    = 64'd0;
    best_t    = 64'd1;
    best_axis = '0;
    // The lockout runs down on every sample, even with detection switched off.
    lock_left = (64'(lock_left) > 64'(s.dt)) ? lock_left - TIME_BITS'(s.dt) : '0;
    if (!det_en) begin
      cand_on   = 1'b0;
      cand_time = '0;
    end else begin
      for (a = 0; a < AXES; a++) begin
        th  = 64'(thr_of(a));
        raw = s.res[a];
        mag = raw[RES_W-1] ? (64'd1 << RES_W) - 64'(raw) : 64'(raw);
        // Strictly greater, so the lowest axis wins a tie; a zero threshold never wins.
        if (th != 64'd0 && mag * best_t > best_r * th) begin
          best_r    = mag;
          best_t    = th;
          best_axis = AXIS_W'(a);
        end
      end
      rel = 64'(rel_cfg);
      if (rel < 64'(REL_MIN)) begin
        rel = 64'(REL_MIN);
      end
      if (rel > 64'(REL_MAX)) begin
        rel = 64'(REL_MAX);
      end
      if ((best_r << RATIO_SH) < rel * best_t) begin
        cand_on   = 1'b0;
        cand_time = '0;
      end else begin
        if (!cand_on || cand_axis != best_axis) begin
          cand_on   = 1'b1;
          cand_axis = best_axis;
          cand_time = TIME_BITS'(s.dt);
        end else begin
          acc       = 64'(cand_time) + 64'(s.dt);
          cand_time = (acc > TIME_TOP) ? '1 : TIME_BITS'(acc);
        end
        if (best_r > best_t && lock_left == '0 && 64'(cand_time) >= 64'(confirm_cfg)) begin
          lock_left = (64'(debounce_cfg) > TIME_TOP) ? '1 : TIME_BITS'(debounce_cfg);
          cand_on   = 1'b0;
          cand_time = '0;
          v.collision    = 1'b1;
          v.contact_axis = best_axis;
        end
      end
    end
    v.suspect_active = cand_on;
    v.suspect_axis   = cand_on ? cand_axis : '0;
    return v;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Sample driver: payload and valid change on the falling edge, beats are taken on the
  // rising edge. After each beat the sender waits a drawn number of cycles.
  // ---------------------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (sample_q.size() != 0) begin
        cur_sample = sample_q.pop_front();
        residual_axis0_i <= cur_sample.res[0];
        residual_axis1_i <= cur_sample.res[1];
        residual_axis2_i <= cur_sample.res[2];
        residual_axis3_i <= cur_sample.res[3];
        residual_axis4_i <= cur_sample.res[4];
        residual_axis5_i <= cur_sample.res[5];
        elapsed_us_i     <= cur_sample.dt;
        in_valid_i       <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // A sample beat is predicted the moment it is taken, so the predicted beats queue up
  // in exactly the order the block must answer them.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      verdict_q.push_back(judge_sample(cur_sample));
      in_taken = 1'b1;
      in_gap   = $urandom_range(0, in_gap_max);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result side: ready drops for a drawn number of cycles after each beat, and for a long
  // stretch whenever a hold-off is requested, which backs the pipeline up into the input.
  // ---------------------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready_i <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: result beat with nothing predicted: expected none, got %b/%0d %b/%0d",
                 $time, collision_o, contact_axis_o, suspect_active_o, suspect_axis_o);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        check_field("collision", want.collision, collision_o);
        check_field("contact_axis", want.contact_axis, contact_axis_o);
        check_field("suspect_active", want.suspect_active, suspect_active_o);
        check_field("suspect_axis", want.suspect_axis, suspect_axis_o);
      end
      out_gap = $urandom_range(0, out_gap_max);
    end
  end

  // Watchdog: any beat on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results outstanding", $time,
               stall_cycles, verdict_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------

  // Writes one register through the configuration channel and mirrors it in the predictor.
  // Only called while the block is idle.
  task automatic write_reg(input crd_reg_e idx, input logic [DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    case (idx)
      REG_DETECT_ENABLE: det_en       = val[0];
      REG_THR_LOW:       thr_lo       = val[THR_W-1:0];
      REG_THR_HIGH:      thr_hi       = val[THR_W-1:0];
      REG_RELEASE_RATIO: rel_cfg      = val[REL_W-1:0];
      REG_CONFIRM:       confirm_cfg  = val[CFGT_W-1:0];
      REG_DEBOUNCE:      debounce_cfg = val[CFGT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Fills the bits above a register's width with noise; the block must ignore them.
  function automatic logic [DATA_W-1:0] with_junk(input logic [DATA_W-1:0] v, input int w);
    logic [DATA_W-1:0] r;
    r = DATA_W'({$urandom, $urandom});
    return (r << w) | v;
  endfunction

  // Waits until every sample has gone in and every predicted beat has come out, then lets
  // the pipeline settle so the next register write finds the block idle.
  task automatic wait_drained();
    @(negedge clk_i);
    while (sample_q.size() != 0 || in_valid_i || verdict_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (LAT + 2) @(negedge clk_i);
  endtask

  // Sets the idling of both sides for the next phase; the queue is then filled on the
  // rising edge, away from the driver's falling-edge reads.
  task automatic begin_fill(input int in_max, input int out_max);
    in_gap_max  = in_max;
    out_gap_max = out_max;
    @(posedge clk_i);
  endtask

  function automatic void queue_sample(input int r0, input int r1, input int r2,
                                       input int r3, input int r4, input int r5,
                                       input int dt);
    sample_t s;
    s.res[0] = RES_W'(r0);
    s.res[1] = RES_W'(r1);
    s.res[2] = RES_W'(r2);
    s.res[3] = RES_W'(r3);
    s.res[4] = RES_W'(r4);
    s.res[5] = RES_W'(r5);
    s.dt     = DT_W'(dt);
    sample_q.push_back(s);
  endfunction

  // Draws a residual of random sign whose size relates to the axis threshold as asked.
  function automatic logic [RES_W-1:0] pick_residual(input int unsigned th,
                                                     input mag_kind_e kind);
    int unsigned m;
    case (kind)
      MAG_QUIET:  m = $urandom_range(0, th / 2);
      MAG_NEAR:   m = $urandom_range(th * 9 / 10, th * 11 / 10 + 1);
      MAG_STRONG: m = $urandom_range(th, th * 3 + 2);
      default:    return RES_W'($urandom);
    endcase
    if (m > 524287) begin
      m = 524287;
    end
    return $urandom_range(0, 1) ? RES_W'(0) - RES_W'(m) : RES_W'(m);
  endfunction

  // A well-formed contact event: one axis rises near or over its threshold for a few samples while
  // the others stay quiet, then the residuals settle again.
  task automatic queue_burst();
    sample_t s;
    int      hot;
    int      len;
    int      i;
    int      a;
    hot = $urandom_range(0, AXES - 1);
    len = $urandom_range(1, 12);
    for (i = 0; i < len + $urandom_range(0, 2); i++) begin
      for (a = 0; a < AXES; a++) begin
        if (a == hot && i < len) begin
          s.res[a] = pick_residual(thr_of(a),
                                   ($urandom_range(0, 3) == 0) ? MAG_NEAR : MAG_STRONG);
        end else begin
          s.res[a] = pick_residual(thr_of(a), MAG_QUIET);
        end
      end
      s.dt = DT_W'($urandom_range(50, 1500));
      sample_q.push_back(s);
    end
  endtask

  // An unstructured sample: any mix of strengths per axis, any elapsed time.
  task automatic queue_noise();
    sample_t s;
    int      a;
    for (a = 0; a < AXES; a++) begin
      s.res[a] = pick_residual(thr_of(a), mag_kind_e'($urandom_range(0, 3)));
    end
    s.dt = $urandom_range(0, 1) ? DT_W'($urandom) : DT_W'($urandom_range(0, 1500));
    sample_q.push_back(s);
  endtask

  task automatic fill_random(input int n);
    while (sample_q.size() < n) begin
      if ($urandom_range(0, 9) < 7) begin
        queue_burst();
      end else begin
        queue_noise();
      end
    end
  endtask

  function automatic logic [TH_W-1:0] pick_threshold();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return TH_W'($urandom);
      2:       return TH_W'($urandom_range(1, 20));
      default: return TH_W'($urandom_range(50, 5000));
    endcase
  endfunction

  // Writes all six registers with a random but mostly realistic setting.
  task automatic randomize_setup(input bit enable);
    logic [THR_W-1:0]  lo;
    logic [THR_W-1:0]  hi;
    logic [CFGT_W-1:0] confirm;
    logic [CFGT_W-1:0] debounce;
    int                a;
    for (a = 0; a < TH_AXES; a++) begin
      lo[TH_W*a +: TH_W] = pick_threshold();
      hi[TH_W*a +: TH_W] = pick_threshold();
    end
    confirm  = ($urandom_range(0, 3) == 0) ? CFGT_W'($urandom) :
                                             CFGT_W'($urandom_range(0, 4000));
    case ($urandom_range(0, 7))
      0:       debounce = '0;
      1:       debounce = CFGT_W'($urandom);
      default: debounce = CFGT_W'($urandom_range(0, 20000));
    endcase
    write_reg(REG_DETECT_ENABLE, with_junk(DATA_W'(enable), 1));
    write_reg(REG_THR_LOW, lo);
    write_reg(REG_THR_HIGH, hi);
    write_reg(REG_RELEASE_RATIO,
              with_junk(($urandom_range(0, 3) == 0) ? DATA_W'($urandom_range(0, 131071)) :
                                                      DATA_W'($urandom_range(45000, 65536)),
                        REL_W));
    write_reg(REG_CONFIRM, with_junk(DATA_W'(confirm), CFGT_W));
    write_reg(REG_DEBOUNCE, with_junk(DATA_W'(debounce), CFGT_W));
  endtask

  // ---------------------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    int ph;
    int i;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Straight out of reset detection is off: nothing is tracked whatever the residuals.
    begin_fill(3, 3);
    queue_sample(524287, 0, 0, 0, 0, 0, 65535);
    queue_sample(-524288, -524288, -524288, -524288, -524288, -524288, 0);
    wait_drained();

    // Axis 1 has a zero threshold, axis 4 the smallest and axis 3 the largest; the release
    // ratio stays at its reset value of about 0.95.
    write_reg(REG_DETECT_ENABLE, 48'h0000_0000_0001);
    write_reg(REG_THR_LOW, 48'h01F4_0000_03E8);
    write_reg(REG_THR_HIGH, 48'h07D0_0001_FFFF);
    write_reg(REG_CONFIRM, 48'h0);
    write_reg(REG_DEBOUNCE, 48'd1000);
    begin_fill(0, 5);
    queue_sample(0, 0, 0, 0, 0, 0, 0);                    // nothing above zero
    queue_sample(-524288, 0, 0, 0, 0, 0, 65535);          // most negative residual
    queue_sample(0, 524287, 0, 0, 0, 0, 5);               // zero threshold never wins
    queue_sample(0, 0, 600, 0, 0, 0, 10);                 // over, but still locked out
    queue_sample(0, 0, -600, 0, 0, 0, 1000);              // lockout ran out
    queue_sample(1000, 0, 0, 0, 0, 2000, 1);              // tie at exactly one
    queue_sample(960, 0, 0, 0, 0, 0, 1);                  // inside the hysteresis band
    queue_sample(940, 0, 0, 0, 0, 0, 1);                  // below release, clears
    queue_sample(0, 0, 0, 0, -2, 0, 1);
    queue_sample(0, 0, 0, -524288, -2, 0, 65535);         // candidate switches axis
    queue_sample(524287, -524288, 524287, -524288, 524287, -524288, 65535);
    queue_sample(1001, 0, 0, 0, 0, 0, 0);
    wait_drained();

    // Detection off while the lockout still runs down; the upper data bits are noise.
    write_reg(REG_DETECT_ENABLE, 48'hABCD_EF01_2340);
    begin_fill(2, 0);
    queue_sample(524287, 0, 0, 0, 0, 0, 400);
    wait_drained();

    // Release ratio below its floor, the largest debounce and the extreme thresholds.
    write_reg(REG_DETECT_ENABLE, 48'h8000_0000_0001);
    write_reg(REG_RELEASE_RATIO, 48'h0);
    write_reg(REG_CONFIRM, 48'd1500);
    write_reg(REG_DEBOUNCE, 48'h0000_00FF_FFFF);
    write_reg(REG_THR_LOW, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_THR_HIGH, 48'h0);
    begin_fill(GAP_MAX, GAP_MAX);
    queue_sample(4, 0, 0, 0, 0, 0, 700);
    queue_sample(0, 4000, 0, 0, 0, 0, 700);
    queue_sample(0, 70000, 0, 0, 0, 0, 800);              // confirm window met exactly
    queue_sample(0, 0, -524288, 0, 0, 0, 65535);
    wait_drained();

    // Release ratio above its ceiling, so a ratio of exactly one still holds a candidate.
    write_reg(REG_RELEASE_RATIO, 48'h0000_0001_FFFF);
    write_reg(REG_THR_HIGH, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_CONFIRM, 48'h0);
    write_reg(REG_DEBOUNCE, 48'h0);
    begin_fill(1, 1);
    queue_sample(0, 0, 0, 65535, 0, 0, 0);
    queue_sample(0, 0, 0, 65534, 0, 0, 0);
    queue_sample(0, 0, 0, 0, 0, -65536, 0);
    wait_drained();

    // Random phases, each with a fresh setting; one of them runs with detection off.
    for (ph = 0; ph < 6; ph++) begin
      randomize_setup(ph != 4);
      begin_fill((ph % 3 == 0) ? 0 : GAP_MAX, (ph % 3 == 2) ? 0 : GAP_MAX);
      fill_random(60);
      wait_drained();
    end

    // Back-pressure: the sender offers beats back to back while the receiver holds off for
    // a long stretch, so the pipeline fills and the input stalls.
    randomize_setup(1'b1);
    begin_fill(0, 0);
    fill_random(80);
    rx_hold_left = HOLD_CYCLES;
    wait_drained();

    // Time saturation: one axis stays over threshold long enough for the accumulated time
    // to clip at its maximum, which just meets the largest confirm window.
    write_reg(REG_DETECT_ENABLE, 48'h1);
    write_reg(REG_THR_LOW, 48'h0064_0064_0064);
    write_reg(REG_THR_HIGH, 48'h0064_0064_0064);
    write_reg(REG_CONFIRM, 48'h0000_00FF_FFFF);
    write_reg(REG_DEBOUNCE, 48'hFFFF_FFFF_FFFF);
    begin_fill(0, 2);
    for (i = 0; i < 262; i++) begin
      queue_sample(pick_residual(100, MAG_QUIET), pick_residual(100, MAG_QUIET),
                   pick_residual(100, MAG_STRONG), pick_residual(100, MAG_QUIET),
                   pick_residual(100, MAG_QUIET), pick_residual(100, MAG_QUIET), 65535);
    end
    wait_drained();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: collision_residual_detector.f
design/crd_pkg.sv
design/crd_lane.sv
design/crd_merge.sv
design/collision_residual_detector.sv
bench/tb_collision_residual_detector.sv
